// File: src/sssp_pkg.sv
// ----------------------------------------------------------------------------
// Shortest path unit package
// Shared constants, types and the state encoding of the run sequencer.
// ----------------------------------------------------------------------------
package sssp_pkg;

  localparam int MaxVertices = 64;
  localparam int VtxBits     = $clog2(MaxVertices);
  localparam int CntBits     = $clog2(MaxVertices + 1);
  localparam int WeightBits  = 16;
  localparam int DistBits    = 22;
  localparam int EdgeDepth   = MaxVertices * MaxVertices;
  localparam int EdgeBits    = $clog2(EdgeDepth);
  localparam logic [DistBits-1:0] DistMax = {DistBits{1'b1}};

  localparam logic [1:0] OpWrite = 2'd0;
  localparam logic [1:0] OpClear = 2'd1;
  localparam logic [1:0] OpRun   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR_A,
    ST_WR_B,
    ST_CLEAR,
    ST_INIT,
    ST_RELAX_RD,
    ST_RELAX,
    ST_OUT_RD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [DistBits-1:0] path_dist;
    logic [VtxBits-1:0]  pred;
    logic                known;
    logic                done;
  } node_t;

endpackage

// File: src/sssp_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module sssp_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/single_source_shortest_path_unit.sv
// Op 0 keeps the input busy after its transaction while it writes the edge both
// ways, op 1 while it clears every presence row. Op 2 with V vertices in use
// initialises the nodes and settles each reachable vertex in turn before its first
// result, then sends V results, one a cycle while out_tready is high. An ignored
// command leaves the unit idle. One transaction is in work at a time. Reset clears
// the edge presence rows, taking no input meanwhile, and sets vertex_count to 64.
// ----------------------------------------------------------------------------
// Single source shortest path unit
// Adjacency matrix in RAM, Dijkstra run by a sequencer over a node RAM.
// ----------------------------------------------------------------------------
module single_source_shortest_path_unit
  import sssp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // first_vertex[5:0], second_vertex[11:6], weight[27:12], zeros
  input  logic [31:0] in_tdata,
  // op[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // vertex[5:0], distance[27:6], predecessor[33:28], zeros
  output logic [39:0] out_tdata,
  // reachable[0]
  output logic        out_tuser,
  output logic        out_tlast
);

  state_t state_r, state_nxt;
  logic [6:0] vc_r;
  logic [CntBits-1:0] n;
  logic [VtxBits-1:0] a_r, b_r;
  logic [WeightBits-1:0] w_r;
  logic [VtxBits-1:0] u_r, u_nxt;
  logic [DistBits-1:0] ud_r, ud_nxt;
  logic [CntBits-1:0] j_r, j_nxt;
  logic found_r, found_nxt;
  logic [VtxBits-1:0] pick_r, pick_nxt;
  logic [DistBits-1:0] pd_r, pd_nxt;

  // Edge weight memory.
  logic ew_we;
  logic [EdgeBits-1:0] ew_waddr, ew_raddr;
  logic [WeightBits-1:0] ew_rdata;
  // Edge presence memory, one row of flags per vertex.
  logic pr_we;
  logic [VtxBits-1:0] pr_waddr, pr_raddr;
  logic [MaxVertices-1:0] pr_wdata, pr_rdata;
  // Node memory.
  logic nd_we;
  logic [VtxBits-1:0] nd_waddr, nd_raddr;
  node_t nd_wdata, nd_rdata;

  logic [VtxBits-1:0] in_a, in_b;
  logic [VtxBits-1:0] jv;
  logic [VtxBits-1:0] jp;
  logic [MaxVertices-1:0] one_a, one_b;
  logic [DistBits:0]  sum;
  logic [DistBits-1:0] nd_dist;
  logic relax_hit;
  logic pres_j;
  logic out_fire;
  node_t upd;

  sssp_ram #(.Width(WeightBits), .Depth(EdgeDepth)) u_edge_ram (
    .clk(clk), .we(ew_we), .waddr(ew_waddr), .wdata(w_r),
    .raddr(ew_raddr), .rdata(ew_rdata)
  );

  sssp_ram #(.Width(MaxVertices), .Depth(MaxVertices)) u_pres_ram (
    .clk(clk), .we(pr_we), .waddr(pr_waddr), .wdata(pr_wdata),
    .raddr(pr_raddr), .rdata(pr_rdata)
  );

  sssp_ram #(.Width($bits(node_t)), .Depth(MaxVertices)) u_node_ram (
    .clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
    .raddr(nd_raddr), .rdata(nd_rdata)
  );

  always_comb begin
    if (vc_r == 7'd0) begin
      n = CntBits'(1);
    end else if (vc_r > 7'(MaxVertices)) begin
      n = CntBits'(MaxVertices);
    end else begin
      n = CntBits'(vc_r);
    end
  end

  assign in_a = in_tdata[5:0];
  assign in_b = in_tdata[11:6];
  assign jv = j_r[VtxBits-1:0];
  assign jp = jv + VtxBits'(1);
  assign one_a = MaxVertices'(1) << a_r;
  assign one_b = MaxVertices'(1) << b_r;
  assign pres_j = pr_rdata[jv];
  assign sum = {1'b0, ud_r} + (DistBits+1)'(ew_rdata);
  assign nd_dist = sum[DistBits] ? DistMax : sum[DistBits-1:0];
  assign relax_hit = pres_j && !nd_rdata.done &&
                     (!nd_rdata.known || nd_dist < nd_rdata.path_dist);
  assign out_fire = out_tvalid && out_tready;

  always_comb begin
    state_nxt = state_r;
    u_nxt = u_r;
    ud_nxt = ud_r;
    j_nxt = j_r;
    found_nxt = found_r;
    pick_nxt = pick_r;
    pd_nxt = pd_r;
    in_tready = 1'b0;
    ew_we = 1'b0;
    ew_waddr = {a_r, b_r};
    ew_raddr = {u_r, jv};
    pr_we = 1'b0;
    pr_waddr = a_r;
    pr_wdata = '0;
    pr_raddr = u_r;
    nd_we = 1'b0;
    nd_waddr = jv;
    nd_wdata = nd_rdata;
    nd_raddr = jv;
    upd = nd_rdata;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        pr_raddr = in_a;
        j_nxt = '0;
        if (in_tvalid) begin
          case (in_tuser)
            OpWrite: begin
              if (in_a != in_b && CntBits'(in_a) < n && CntBits'(in_b) < n) begin
                state_nxt = ST_WR_A;
              end
            end
            OpClear: state_nxt = ST_CLEAR;
            OpRun: begin
              if (CntBits'(in_a) < n) begin
                state_nxt = ST_INIT;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WR_A: begin
        ew_we = 1'b1;
        ew_waddr = {a_r, b_r};
        pr_we = 1'b1;
        pr_waddr = a_r;
        pr_wdata = pr_rdata | one_b;
        pr_raddr = b_r;
        state_nxt = ST_WR_B;
      end
      ST_WR_B: begin
        ew_we = 1'b1;
        ew_waddr = {b_r, a_r};
        pr_we = 1'b1;
        pr_waddr = b_r;
        pr_wdata = pr_rdata | one_a;
        state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        pr_we = 1'b1;
        pr_waddr = jv;
        pr_wdata = '0;
        j_nxt = j_r + CntBits'(1);
        if (j_r == CntBits'(MaxVertices - 1)) begin
          j_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_INIT: begin
        nd_we = 1'b1;
        nd_waddr = jv;
        nd_wdata.path_dist = '0;
        nd_wdata.pred = a_r;
        nd_wdata.known = (jv == a_r);
        nd_wdata.done = (jv == a_r);
        j_nxt = j_r + CntBits'(1);
        if (j_nxt == n) begin
          j_nxt = '0;
          u_nxt = a_r;
          ud_nxt = '0;
          state_nxt = ST_RELAX_RD;
        end
      end
      ST_RELAX_RD: begin
        j_nxt = '0;
        found_nxt = 1'b0;
        nd_raddr = '0;
        ew_raddr = {u_r, {VtxBits{1'b0}}};
        state_nxt = ST_RELAX;
      end
      ST_RELAX: begin
        // Each entry is relaxed and then weighed as the next vertex to settle.
        if (jv == u_r) begin
          nd_we = 1'b1;
          upd.done = 1'b1;
        end else if (relax_hit) begin
          nd_we = 1'b1;
          upd.path_dist = nd_dist;
          upd.pred = u_r;
          upd.known = 1'b1;
        end
        nd_wdata = upd;
        if (!upd.done && upd.known && (!found_r || upd.path_dist < pd_r)) begin
          found_nxt = 1'b1;
          pick_nxt = jv;
          pd_nxt = upd.path_dist;
        end
        j_nxt = j_r + CntBits'(1);
        nd_raddr = jp;
        ew_raddr = {u_r, jp};
        if (j_nxt == n) begin
          j_nxt = '0;
          nd_raddr = '0;
          if (found_nxt) begin
            u_nxt = pick_nxt;
            ud_nxt = pd_nxt;
            state_nxt = ST_RELAX_RD;
          end else begin
            state_nxt = ST_OUT_RD;
          end
        end
      end
      ST_OUT_RD: begin
        nd_raddr = jv;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        nd_raddr = jv;
        if (out_fire) begin
          j_nxt = j_r + CntBits'(1);
          nd_raddr = jp;
          if (j_nxt == n) begin
            j_nxt = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      vc_r <= 7'(MaxVertices);
      j_r <= '0;
      found_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        vc_r <= cfg_wdata;
      end
      state_r <= state_nxt;
      j_r <= j_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_r <= in_a;
      b_r <= in_b;
      w_r <= in_tdata[27:12];
    end
    u_r <= u_nxt;
    ud_r <= ud_nxt;
    pick_r <= pick_nxt;
    pd_r <= pd_nxt;
  end

  assign out_tvalid = (state_r == ST_OUT);
  assign out_tlast = (j_r + CntBits'(1) == n);
  assign out_tuser = nd_rdata.known;
  assign out_tdata = {6'd0,
                      nd_rdata.known ? nd_rdata.pred : a_r,
                      nd_rdata.known ? nd_rdata.path_dist : {DistBits{1'b0}},
                      jv};

endmodule
